// ===== design/sfrc_pkg.sv =====
// Shared types and constants for the SLIP frame receiver with checksum
`timescale 1ns / 1ps
`default_nettype none

package sfrc_pkg;

    localparam int MAX_FRAME_DEF = 64;
    localparam int CMD_DEPTH     = 2;
    localparam int RES_DEPTH     = 2;

    localparam logic [7:0] DELIM   = 8'hC0;
    localparam logic [7:0] ESC     = 8'hDB;
    localparam logic [7:0] ESC_ESC = 8'hDD;
    localparam logic [7:0] ESC_END = 8'hDC;

    localparam logic [6:0]  RAW_SAT         = 7'd127;
    localparam logic [6:0]  MIN_RAW_RESET   = 7'd5;
    localparam logic [15:0] LINK_READY_RESET = 16'hFDE2;

    typedef enum logic [0:0] {
        REG_MIN_RAW    = 1'b0,
        REG_LINK_READY = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_GOOD  = 2'd0,
        ST_CSUM  = 2'd1,
        ST_SHORT = 2'd2,
        ST_LONG  = 2'd3
    } status_t;

    typedef struct packed {
        logic        frame_end;
        logic        latch;
        logic [7:0]  data;
        logic [5:0]  idx;
        status_t     status;
        logic [15:0] fn;
        logic [15:0] src;
    } cmd_t;

    typedef struct packed {
        logic        frame_end;
        logic [7:0]  data;
        logic [5:0]  idx;
        status_t     status;
        logic [15:0] fn;
        logic [15:0] src;
        logic [15:0] slave;
    } res_t;

endpackage

`default_nettype wire

// ===== design/sfrc_fifo.sv =====
// Small register queue used between the stages and at the result side
`timescale 1ns / 1ps
`default_nettype none

module sfrc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/sfrc_front.sv =====
// Front stage: configuration, unescaping, frame tracking and checksum verdict
`timescale 1ns / 1ps
`default_nettype none

module sfrc_front #(
    parameter int MAX_FRAME = sfrc_pkg::MAX_FRAME_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [0:0]        wr_index,
    input  wire logic [15:0]       wr_data,
    input  wire logic              accept,
    input  wire logic [7:0]        rx_byte,
    output logic                   cmd_valid,
    output sfrc_pkg::cmd_t         cmd
);

    import sfrc_pkg::*;

    localparam int CW = $clog2(MAX_FRAME);
    localparam logic [CW-1:0] CAP = CW'(MAX_FRAME - 2);

    logic [6:0]    min_raw_reg;
    logic [15:0]   link_code_reg;

    logic          in_frame_reg, in_frame_next;
    logic          esc_reg, esc_next;
    logic [6:0]    raw_reg, raw_next;
    logic [CW-1:0] dec_reg, dec_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    held_reg, held_next;
    logic [15:0]   fn_reg, fn_next;
    logic [15:0]   src_reg, src_next;

    logic [6:0]    raw_inc;
    logic [7:0]    dec_byte;
    status_t       st;

    assign raw_inc  = (raw_reg < RAW_SAT) ? raw_reg + 7'd1 : raw_reg;
    assign dec_byte = !esc_reg ? rx_byte : ((rx_byte == ESC_END) ? DELIM : ESC);

    always_comb
    begin
        if (dec_reg > CAP)
        begin
            st = ST_LONG;
        end
        else if (raw_inc < min_raw_reg)
        begin
            st = ST_SHORT;
        end
        else if (sum_reg != held_reg)
        begin
            st = ST_CSUM;
        end
        else
        begin
            st = ST_GOOD;
        end
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        raw_next      = raw_reg;
        dec_next      = dec_reg;
        sum_next      = sum_reg;
        held_next     = held_reg;
        fn_next       = fn_reg;
        src_next      = src_reg;
        cmd_valid     = 1'b0;
        cmd           = '0;
        if (accept)
        begin
            if (!in_frame_reg || (rx_byte == DELIM && st == ST_SHORT))
            begin
                if (rx_byte == DELIM)
                begin
                    in_frame_next = 1'b1;
                    esc_next      = 1'b0;
                    raw_next      = 7'd1;
                    dec_next      = '0;
                    sum_next      = '0;
                    held_next     = '0;
                    fn_next       = '0;
                    src_next      = '0;
                end
            end
            else if (rx_byte == DELIM)
            begin
                in_frame_next = 1'b0;
            end
            if (in_frame_reg)
            begin
                if (rx_byte == DELIM)
                begin
                    cmd_valid     = 1'b1;
                    cmd.frame_end = 1'b1;
                    cmd.status    = st;
                    cmd.fn        = fn_reg;
                    cmd.src       = src_reg;
                    cmd.latch     = (st == ST_GOOD) && (fn_reg == link_code_reg);
                end
                else
                begin
                    raw_next = raw_inc;
                    if (!esc_reg && rx_byte == ESC)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        esc_next = 1'b0;
                        if (dec_reg >= CAP)
                        begin
                            dec_next = CAP + 1'b1;
                        end
                        else
                        begin
                            if (dec_reg >= CW'(2))
                            begin
                                sum_next = sum_reg + held_reg;
                            end
                            held_next = dec_byte;
                            if (dec_reg == CW'(0))
                            begin
                                fn_next = {dec_byte, fn_reg[7:0]};
                            end
                            else if (dec_reg == CW'(1))
                            begin
                                fn_next = {fn_reg[15:8], dec_byte};
                            end
                            else if (dec_reg == CW'(2))
                            begin
                                src_next = {dec_byte, src_reg[7:0]};
                            end
                            else if (dec_reg == CW'(3))
                            begin
                                src_next = {src_reg[15:8], dec_byte};
                            end
                            dec_next  = dec_reg + 1'b1;
                            cmd_valid = 1'b1;
                            cmd.data  = dec_byte;
                            cmd.idx   = 6'(dec_reg);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_raw_reg   <= MIN_RAW_RESET;
            link_code_reg <= LINK_READY_RESET;
        end
        else if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_MIN_RAW:    min_raw_reg   <= wr_data[6:0];
                REG_LINK_READY: link_code_reg <= wr_data;
                default:        min_raw_reg   <= min_raw_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            raw_reg      <= '0;
            dec_reg      <= '0;
            sum_reg      <= '0;
            held_reg     <= '0;
            fn_reg       <= '0;
            src_reg      <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            raw_reg      <= raw_next;
            dec_reg      <= dec_next;
            sum_reg      <= sum_next;
            held_reg     <= held_next;
            fn_reg       <= fn_next;
            src_reg      <= src_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/sfrc_back.sv =====
// Back stage: slave id latch and result formatting
`timescale 1ns / 1ps
`default_nettype none

module sfrc_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire sfrc_pkg::cmd_t cmd,
    output logic                cmd_pop,
    input  wire logic           res_full,
    output logic                res_push,
    output sfrc_pkg::res_t      res
);

    import sfrc_pkg::*;

    logic [15:0] slave_reg, slave_next;

    assign cmd_pop  = cmd_valid && !res_full;
    assign res_push = cmd_pop;

    always_comb
    begin
        slave_next = slave_reg;
        if (cmd_pop && cmd.frame_end && cmd.latch)
        begin
            slave_next = cmd.src;
        end
        res.frame_end = cmd.frame_end;
        res.data      = cmd.data;
        res.idx       = cmd.idx;
        res.status    = cmd.status;
        res.fn        = cmd.fn;
        res.src       = cmd.src;
        res.slave     = (cmd.frame_end && cmd.latch) ? cmd.src : slave_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_reg <= '0;
        end
        else
        begin
            slave_reg <= slave_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/slip_frame_receiver_checksum_unit.sv =====
// Top level of the SLIP frame receiver with byte-sum checksum
// Path: a result is registered in the command queue, then the back stage
//   moves it into the result queue while that has room; pop takes it out.
// Throughput: one byte per cycle unless full; one or no result per byte.
// Reset: frame state idle, slave id 0, min_raw_length 5, link_ready_code
//   0xFDE2, both queues empty.
`timescale 1ns / 1ps
`default_nettype none

module slip_frame_receiver_checksum_unit #(
    parameter int MAX_FRAME = sfrc_pkg::MAX_FRAME_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [0:0]  wr_index,
    input  wire logic [15:0] wr_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       data_byte,
    output logic [5:0]       byte_index,
    output logic             frame_end,
    output logic [1:0]       status,
    output logic [15:0]      function_code,
    output logic [15:0]      source_id,
    output logic [15:0]      slave_id
);

    import sfrc_pkg::*;

    logic accept;
    logic cmd_valid_in, cmd_empty, cmd_pop;
    cmd_t cmd_in, cmd_out;
    logic res_full, res_push;
    res_t res_in, res_out;

    assign accept = push && !full;

    sfrc_front #(
        .MAX_FRAME(MAX_FRAME)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .cmd_valid(cmd_valid_in),
        .cmd      (cmd_in)
    );

    sfrc_fifo #(
        .WIDTH($bits(cmd_t)),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_valid_in),
        .wr_data(cmd_in),
        .full   (full),
        .rd_en  (cmd_pop),
        .rd_data(cmd_out),
        .empty  (cmd_empty)
    );

    sfrc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(!cmd_empty),
        .cmd      (cmd_out),
        .cmd_pop  (cmd_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res_in)
    );

    sfrc_fifo #(
        .WIDTH($bits(res_t)),
        .DEPTH(RES_DEPTH)
    ) u_res_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (res_push),
        .wr_data(res_in),
        .full   (res_full),
        .rd_en  (pop),
        .rd_data(res_out),
        .empty  (empty)
    );

    assign data_byte     = res_out.data;
    assign byte_index    = res_out.idx;
    assign frame_end     = res_out.frame_end;
    assign status        = res_out.status;
    assign function_code = res_out.fn;
    assign source_id     = res_out.src;
    assign slave_id      = res_out.slave;

endmodule

`default_nettype wire

// ===== design/sfrc_checker.sv =====
// Port-level checks for the SLIP frame receiver, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module sfrc_port_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic        full,
    input wire logic [7:0]  data_byte,
    input wire logic [5:0]  byte_index,
    input wire logic        frame_end,
    input wire logic [1:0]  status,
    input wire logic [15:0] function_code,
    input wire logic [15:0] source_id,
    input wire logic [15:0] slave_id
);

    import sfrc_pkg::*;

    a_reset_clears: assert property (@(posedge clk)
        !rst_n |-> (empty && !full))
        else $error("queues not empty during reset");

    a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !frame_end) |->
            (status == ST_GOOD && function_code == 16'd0 && source_id == 16'd0))
        else $error("data result carries frame status fields");

    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_end) |-> (data_byte == 8'd0 && byte_index == 6'd0))
        else $error("status result carries data fields");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(data_byte) && $stable(frame_end) && $stable(slave_id)))
        else $error("stalled result changed");

endmodule

bind slip_frame_receiver_checksum_unit sfrc_port_checker u_sfrc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .full         (full),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .frame_end    (frame_end),
    .status       (status),
    .function_code(function_code),
    .source_id    (source_id),
    .slave_id     (slave_id)
);

`default_nettype wire
